>>> rtl/core/bnnls_pkg.sv
// Shared types, codes and constants of the bounded NNLS coordinate descent solver.
`timescale 1ns / 1ps

package bnnls_pkg;

  typedef enum logic [1:0] {
    FUNC_LOAD_A    = 2'd0,
    FUNC_LOAD_B    = 2'd1,
    FUNC_LOAD_WARM = 2'd2,
    FUNC_SOLVE     = 2'd3
  } func_t;

  localparam logic [1:0] CFG_COLS  = 2'd0;
  localparam logic [1:0] CFG_ROWS  = 2'd1;
  localparam logic [1:0] CFG_LIMIT = 2'd2;
  localparam logic [1:0] CFG_TOL   = 2'd3;

  localparam logic [4:0]  COLS_RST  = 5'd16;
  localparam logic [6:0]  ROWS_RST  = 7'd64;
  localparam logic [30:0] LIMIT_RST = 31'h7FFF_FFFF;
  localparam logic [15:0] TOL_RST   = 16'd43;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  // Quotient caps of the serial divider, and 1.0 in Q32.32.
  localparam logic [48:0] STEP_CAP = 49'h0_0001_0000_0000;
  localparam logic [48:0] MEAS_CAP = 49'h1_0000_0000_0000;
  localparam logic [63:0] ONE_Q32  = 64'h0000_0001_0000_0000;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63])) begin
      return a[63] ? S64_MIN : S64_MAX;
    end
    return s;
  endfunction

endpackage

>>> rtl/core/bounded_nnls_coordinate_descent.sv
// Top level of the bounded nonnegative least squares solver by coordinate descent.
//
// Input words on the s_axis channel carry an operation in tuser: load an element of A,
// load an element of b, load a warm start entry, or solve. A load is taken while idle
// and writes one store entry. A solve forms A'A and A'b, applies the warm start if asked,
// runs up to 2*cols sweeps and then sends one m_axis word per column, tlast on the final.
// Registers are written over the cfg channel, which is always ready; write them only
// while the block is idle.
// Throughput: loads go at one word per cycle while the block is idle. Only one solve is in flight; s_axis_tready
// stays low from the solve word until the last result word has been taken.
// Steps of a solve, with the radix-2 serial divider for each division:
//   Gram and A'b: each product is read, multiplied and accumulated in turn.
//   Warm start: each entry is read and written; a nonzero entry adds a residual update.
//   Each column visit of a sweep: read and check, then up to two divisions
//   and a residual update over all columns when x changes.
//   Output: each word is read, written and held until the receiver takes it.
// A stalled receiver simply holds the block in its output state; nothing is lost.
// Reset returns the registers to their defaults and the sweep count to zero; the
// stores are not cleared and must be loaded before a solve.
`timescale 1ns / 1ps

module bounded_nnls_coordinate_descent
  import bnnls_pkg::*;
#(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // row_index[5:0], col_index[9:6], value[41:10], use_warm_start[42], zeros above
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // func[1:0]
  input  logic [1:0]             s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // col_index_res[3:0], solution[34:4], sweeps_used[40:35], zeros above
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [31:0]            cfg_data
);

  localparam int CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CNT_W = $clog2(MAX_COLS + 1);
  localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RCW   = $clog2(MAX_ROWS + 1);
  localparam int AW    = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1;
  localparam int GW    = (MAX_COLS > 1) ? $clog2(MAX_COLS * MAX_COLS) : 1;
  localparam int SW_W  = $clog2(2 * MAX_COLS + 1);

  typedef enum logic [4:0] {
    ST_IDLE, ST_G_RD, ST_G_MUL, ST_G_ACC, ST_W_RD, ST_W_WR, ST_W_NEXT,
    ST_U_RD, ST_U_M1, ST_U_M2, ST_U_ACC, ST_S_RD, ST_S_CHK, ST_S_DEC,
    ST_S_MEAS, ST_S_NEXT, ST_DIV, ST_O_RD, ST_O_WR, ST_O_WAIT
  } state_t;

  // Configuration registers
  logic [4:0]  cols_in_use;
  logic [6:0]  rows_in_use;
  logic [30:0] upper_limit;
  logic [15:0] tolerance_per_column;

  // Stores
  logic signed [31:0] a_mem   [MAX_ROWS * MAX_COLS];
  logic signed [31:0] b_mem   [MAX_ROWS];
  logic signed [31:0] w_mem   [MAX_COLS];
  logic signed [63:0] g_mem   [MAX_COLS * MAX_COLS];
  logic signed [63:0] r_mem   [MAX_COLS];
  logic [30:0]        s_mem   [MAX_COLS];

  logic signed [31:0] a_q0, a_q1, b_q, w_q;
  logic signed [63:0] g_q, r_q;
  logic [30:0]        s_q;

  logic           a_we, b_we, w_we, g_we, r_we, s_we;
  logic [AW-1:0]  a_waddr, a_raddr0, a_raddr1;
  logic [RIW-1:0] b_waddr, b_raddr;
  logic [CIW-1:0] w_waddr, w_raddr, r_waddr, r_raddr, s_waddr, s_raddr;
  logic [GW-1:0]  g_waddr, g_raddr;
  logic signed [63:0] g_wdata, r_wdata;
  logic [30:0]        s_wdata;

  // Sequencer state
  state_t state, ret_state, dv_ret;
  logic [CNT_W-1:0] ci, cj, ck;
  logic [RIW-1:0]   cr;
  logic [SW_W-1:0]  sw;
  logic             warm_en;
  logic signed [63:0] acc, prod;
  logic signed [33:0] delta;
  logic [30:0]        xv;
  logic               rneg;
  logic [63:0]        meas;
  logic               meas_set;
  logic [64:0]        plo, phi;
  logic [31:0]        g_hi;
  logic               mneg;

  // Serial divider
  logic [95:0] dv_num;
  logic [63:0] dv_rem, dv_den;
  logic [49:0] dv_q;
  logic [48:0] dv_cap;
  logic [6:0]  dv_cnt;
  logic [64:0] dv_rem2, dv_remn;
  logic        dv_ge;
  logic [49:0] dv_qn;

  // Input word fields
  func_t              in_func;
  logic [5:0]         in_row;
  logic [3:0]         in_col;
  logic signed [31:0] in_val;
  logic               in_warm;
  logic               s_acc;

  assign in_func = func_t'(s_axis_tuser);
  assign in_row  = s_axis_tdata[5:0];
  assign in_col  = s_axis_tdata[9:6];
  assign in_val  = s_axis_tdata[41:10];
  assign in_warm = s_axis_tdata[42];

  assign s_axis_tready = (state == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  // Sizes clamped to the store dimensions
  logic [CNT_W-1:0] cols, cols_m1;
  logic [RCW-1:0]   rows;
  logic [RIW-1:0]   rows_m1;
  logic [SW_W-1:0]  max_sw;
  logic [63:0]      tol;

  always_comb begin
    if (cols_in_use == 5'd0) begin
      cols = CNT_W'(1);
    end else if (32'(cols_in_use) > MAX_COLS) begin
      cols = CNT_W'(MAX_COLS);
    end else begin
      cols = CNT_W'(cols_in_use);
    end
    if (rows_in_use == 7'd0) begin
      rows = RCW'(1);
    end else if (32'(rows_in_use) > MAX_ROWS) begin
      rows = RCW'(MAX_ROWS);
    end else begin
      rows = RCW'(rows_in_use);
    end
    cols_m1 = cols - CNT_W'(1);
    rows_m1 = RIW'(rows - RCW'(1));
    max_sw  = SW_W'({cols, 1'b0});
    tol     = 64'(21'(tolerance_per_column) * 21'(cols));
  end

  // Column-step arithmetic for the decision state
  logic signed [34:0] d35, x35, lim35, xn35;
  logic               c_low, c_high;
  always_comb begin
    d35    = rneg ? -$signed({2'b00, dv_q[32:0]}) : $signed({2'b00, dv_q[32:0]});
    x35    = $signed({4'b0000, xv});
    lim35  = $signed({4'b0000, upper_limit});
    xn35   = x35 + d35;
    c_low  = (-d35) > x35;
    c_high = (lim35 - d35) < x35;
  end

  // Warm start entry clamped to [0, upper_limit], or zero when the warm start is not asked for
  logic [30:0] warm_x;
  always_comb begin
    if (!warm_en || w_q[31]) begin
      warm_x = '0;
    end else if (w_q[30:0] > upper_limit) begin
      warm_x = upper_limit;
    end else begin
      warm_x = w_q[30:0];
    end
  end

  // Residual update arithmetic: r -= (G * delta) >> 16, saturated
  logic [32:0]        mv;
  logic [63:0]        mg;
  logic [64:0]        msum;
  logic [63:0]        mmag;
  logic signed [63:0] res_n, acc_n;
  always_comb begin
    mv   = delta[33] ? 33'(-delta) : 33'(delta);
    mg   = g_q[63] ? 64'(-g_q) : 64'(g_q);
    msum = {phi[48:0], 16'h0000} + {16'h0000, plo[64:16]};
    if ((phi[64:47] != '0) || (msum > 65'(S64_MAX))) begin
      mmag = 64'(S64_MAX);
    end else begin
      mmag = msum[63:0];
    end
    res_n = sat_add64(r_q, mneg ? $signed(mmag) : -$signed(mmag));
    acc_n = sat_add64(acc, prod);
  end

  always_comb begin
    dv_rem2 = {dv_rem, dv_num[95]};
    dv_ge   = dv_rem2 >= {1'b0, dv_den};
    dv_remn = dv_ge ? (dv_rem2 - {1'b0, dv_den}) : dv_rem2;
    dv_qn   = {dv_q[48:0], dv_ge};
  end

  logic [SW_W+5:0]  sw_ext;
  logic [CNT_W+3:0] ci_ext;
  assign sw_ext = {6'b000000, sw};
  assign ci_ext = {4'b0000, ci};

  // Store addressing and write enables
  always_comb begin
    a_we     = s_acc && (in_func == FUNC_LOAD_A) && (32'(in_row) < MAX_ROWS)
               && (32'(in_col) < MAX_COLS);
    a_waddr  = AW'(32'(in_row) * MAX_COLS + 32'(in_col));
    b_we     = s_acc && (in_func == FUNC_LOAD_B) && (32'(in_row) < MAX_ROWS);
    b_waddr  = RIW'(in_row);
    w_we     = s_acc && (in_func == FUNC_LOAD_WARM) && (32'(in_col) < MAX_COLS);
    w_waddr  = CIW'(in_col);

    a_raddr0 = AW'(32'(cr) * MAX_COLS + 32'(ci));
    a_raddr1 = AW'(32'(cr) * MAX_COLS + 32'(cj));
    b_raddr  = cr;
    w_raddr  = ci[CIW-1:0];
    s_raddr  = ci[CIW-1:0];
    if (state == ST_S_RD) begin
      g_raddr = GW'(32'(ci) * (MAX_COLS + 1));
      r_raddr = ci[CIW-1:0];
    end else begin
      g_raddr = GW'(32'(ck) * MAX_COLS + 32'(ci));
      r_raddr = ck[CIW-1:0];
    end

    g_we    = (state == ST_G_ACC) && (cr == rows_m1) && (cj != cols);
    g_waddr = GW'(32'(ci) * MAX_COLS + 32'(cj));
    g_wdata = acc_n;

    r_we    = 1'b0;
    r_waddr = ci[CIW-1:0];
    r_wdata = acc_n;
    if ((state == ST_G_ACC) && (cr == rows_m1) && (cj == cols)) begin
      r_we = 1'b1;
    end else if (state == ST_U_ACC) begin
      r_we    = 1'b1;
      r_waddr = ck[CIW-1:0];
      r_wdata = res_n;
    end

    s_we    = 1'b0;
    s_waddr = ci[CIW-1:0];
    s_wdata = warm_x;
    if (state == ST_W_WR) begin
      s_we = 1'b1;
    end else if (state == ST_S_DEC) begin
      if (c_low) begin
        s_we    = (xv != '0);
        s_wdata = '0;
      end else if (c_high) begin
        s_we    = (xv != upper_limit);
        s_wdata = upper_limit;
      end else begin
        s_we    = (d35 != '0);
        s_wdata = xn35[30:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_we) a_mem[a_waddr] <= in_val;
    if (b_we) b_mem[b_waddr] <= in_val;
    if (w_we) w_mem[w_waddr] <= in_val;
    if (g_we) g_mem[g_waddr] <= g_wdata;
    if (r_we) r_mem[r_waddr] <= r_wdata;
    if (s_we) s_mem[s_waddr] <= s_wdata;
    a_q0 <= a_mem[a_raddr0];
    a_q1 <= a_mem[a_raddr1];
    b_q  <= b_mem[b_raddr];
    w_q  <= w_mem[w_raddr];
    g_q  <= g_mem[g_raddr];
    r_q  <= r_mem[r_raddr];
    s_q  <= s_mem[s_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_in_use          <= COLS_RST;
      rows_in_use          <= ROWS_RST;
      upper_limit          <= LIMIT_RST;
      tolerance_per_column <= TOL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_COLS:  cols_in_use          <= cfg_data[4:0];
        CFG_ROWS:  rows_in_use          <= cfg_data[6:0];
        CFG_LIMIT: upper_limit          <= cfg_data[30:0];
        CFG_TOL:   tolerance_per_column <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      ret_state     <= ST_IDLE;
      dv_ret        <= ST_IDLE;
      sw            <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_acc && (in_func == FUNC_SOLVE)) begin
            warm_en <= in_warm;
            ci      <= '0;
            cj      <= '0;
            cr      <= '0;
            acc     <= '0;
            state   <= ST_G_RD;
          end
        end
        ST_G_RD: state <= ST_G_MUL;
        ST_G_MUL: begin
          prod  <= a_q0 * ((cj == cols) ? b_q : a_q1);
          state <= ST_G_ACC;
        end
        ST_G_ACC: begin
          if (cr == rows_m1) begin
            acc <= '0;
            cr  <= '0;
            if (cj == cols) begin
              cj <= '0;
              if (ci == cols_m1) begin
                ci    <= '0;
                state <= ST_W_RD;
              end else begin
                ci    <= ci + CNT_W'(1);
                state <= ST_G_RD;
              end
            end else begin
              cj    <= cj + CNT_W'(1);
              state <= ST_G_RD;
            end
          end else begin
            acc   <= acc_n;
            cr    <= cr + RIW'(1);
            state <= ST_G_RD;
          end
        end
        ST_W_RD: state <= ST_W_WR;
        ST_W_WR: begin
          if (warm_x != '0) begin
            delta     <= $signed({3'b000, warm_x});
            ck        <= '0;
            ret_state <= ST_W_NEXT;
            state     <= ST_U_RD;
          end else begin
            state <= ST_W_NEXT;
          end
        end
        ST_W_NEXT: begin
          if (ci == cols_m1) begin
            ci    <= '0;
            sw    <= SW_W'(1);
            meas  <= '0;
            state <= ST_S_RD;
          end else begin
            ci    <= ci + CNT_W'(1);
            state <= ST_W_RD;
          end
        end
        ST_U_RD: state <= ST_U_M1;
        ST_U_M1: begin
          plo   <= {33'd0, mg[31:0]} * {32'd0, mv};
          g_hi  <= mg[63:32];
          mneg  <= g_q[63] ^ delta[33];
          state <= ST_U_M2;
        end
        ST_U_M2: begin
          phi   <= {33'd0, g_hi} * {32'd0, mv};
          state <= ST_U_ACC;
        end
        ST_U_ACC: begin
          if (ck == cols_m1) begin
            state <= ret_state;
          end else begin
            ck    <= ck + CNT_W'(1);
            state <= ST_U_RD;
          end
        end
        ST_S_RD: state <= ST_S_CHK;
        ST_S_CHK: begin
          if (g_q[63] || (g_q == '0)) begin
            state <= ST_S_NEXT;
          end else begin
            xv     <= s_q;
            rneg   <= r_q[63];
            dv_num <= {16'h0000, (r_q[63] ? 64'(-r_q) : 64'(r_q)), 16'h0000};
            dv_den <= 64'(g_q);
            dv_cap <= STEP_CAP;
            dv_rem <= '0;
            dv_q   <= '0;
            dv_cnt <= 7'd95;
            dv_ret <= ST_S_DEC;
            state  <= ST_DIV;
          end
        end
        ST_S_DEC: begin
          ck        <= '0;
          ret_state <= ST_S_NEXT;
          if (c_low) begin
            if (xv != '0) begin
              delta <= -$signed({3'b000, xv});
              meas  <= ONE_Q32;
              state <= ST_U_RD;
            end else begin
              state <= ST_S_NEXT;
            end
          end else if (c_high) begin
            if (xv != upper_limit) begin
              delta    <= $signed({3'b000, upper_limit - xv});
              meas_set <= 1'b1;
              if (upper_limit != '0) begin
                dv_num <= {33'd0, upper_limit - xv, 32'd0};
                dv_den <= 64'(upper_limit);
                dv_cap <= MEAS_CAP;
                dv_rem <= '0;
                dv_q   <= '0;
                dv_cnt <= 7'd95;
                dv_ret <= ST_S_MEAS;
                state  <= ST_DIV;
              end else begin
                meas  <= 64'(MEAS_CAP);
                state <= ST_U_RD;
              end
            end else begin
              state <= ST_S_NEXT;
            end
          end else if (d35 != '0) begin
            delta    <= d35[33:0];
            meas_set <= 1'b0;
            if (xn35 > 0) begin
              dv_num <= {31'd0, (d35[34] ? 33'(-d35) : 33'(d35)), 32'd0};
              dv_den <= 64'(xn35[30:0]);
              dv_cap <= MEAS_CAP;
              dv_rem <= '0;
              dv_q   <= '0;
              dv_cnt <= 7'd95;
              dv_ret <= ST_S_MEAS;
              state  <= ST_DIV;
            end else begin
              dv_q  <= 50'(MEAS_CAP);
              state <= ST_S_MEAS;
            end
          end else begin
            state <= ST_S_NEXT;
          end
        end
        ST_S_MEAS: begin
          // A clamp replaces the change measure; a free step adds to it.
          if (meas_set) begin
            meas <= 64'(dv_q);
          end else if ({1'b0, meas} + 65'(dv_q) > 65'h0_FFFF_FFFF_FFFF_FFFF) begin
            meas <= '1;
          end else begin
            meas <= meas + 64'(dv_q);
          end
          state <= ST_U_RD;
        end
        ST_S_NEXT: begin
          if (ci == cols_m1) begin
            ci <= '0;
            if ((meas < tol) || (sw == max_sw)) begin
              state <= ST_O_RD;
            end else begin
              sw    <= sw + SW_W'(1);
              meas  <= '0;
              state <= ST_S_RD;
            end
          end else begin
            ci    <= ci + CNT_W'(1);
            state <= ST_S_RD;
          end
        end
        ST_DIV: begin
          if (dv_q > {1'b0, dv_cap}) begin
            dv_q  <= {1'b0, dv_cap};
            state <= dv_ret;
          end else begin
            dv_rem <= dv_remn[63:0];
            dv_num <= {dv_num[94:0], 1'b0};
            if (dv_cnt == '0) begin
              dv_q  <= (dv_qn > {1'b0, dv_cap}) ? {1'b0, dv_cap} : dv_qn;
              state <= dv_ret;
            end else begin
              dv_q   <= dv_qn;
              dv_cnt <= dv_cnt - 7'd1;
            end
          end
        end
        ST_O_RD: state <= ST_O_WR;
        ST_O_WR: begin
          m_axis_tdata  <= {7'd0, sw_ext[5:0], s_q, ci_ext[3:0]};
          m_axis_tlast  <= (ci == cols_m1);
          m_axis_tvalid <= 1'b1;
          state         <= ST_O_WAIT;
        end
        ST_O_WAIT: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            if (ci == cols_m1) begin
              state <= ST_IDLE;
            end else begin
              ci    <= ci + CNT_W'(1);
              state <= ST_O_RD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/bnnls_chk.sv
// Port-level assertion checker for the solver, bound to its top level.
`timescale 1ns / 1ps

module bnnls_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // A word that is offered but not taken must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result word changed while stalled");

  // No new input is taken while results of a solve are being sent.
  a_one_solve: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a result is pending");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // Between the words of one solution the input side stays closed.
  a_mid_frame: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> !s_axis_tready)
    else $error("input reopened inside a solution");

endmodule

bind bounded_nnls_coordinate_descent bnnls_chk u_bnnls_chk (.*);
